// ===== hdl/maop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maop_pkg
// Shared types and constants of the multi-asset option payoff block.
// ----------------------------------------------------------------------------
package maop_pkg;

  localparam int unsigned NumAssets  = 4;
  localparam int unsigned PriceW     = 32;
  localparam int unsigned WeightW    = 17;
  localparam int unsigned WeightFrac = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  // product of a price and a weight, and the term after the fraction drop
  localparam int unsigned ProdW      = PriceW + WeightW;
  localparam int unsigned TermW      = ProdW - WeightFrac;
  localparam int unsigned PairW      = TermW + 1;
  localparam int unsigned SumW       = PairW + 1;
  // signed operand ahead of the strike stage, and the signed payoff
  localparam int unsigned XW         = SumW + 1;
  localparam int unsigned VW         = XW + 2;

  typedef enum logic [2:0] {
    KIND_BASKET   = 3'd0,
    KIND_BEST_OF  = 3'd1,
    KIND_WORST_OF = 3'd2,
    KIND_EXCHANGE = 3'd3,
    KIND_SPREAD   = 3'd4
  } payoff_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAYOFF_KIND   = 3'd0,
    REG_CALL_NOT_PUT  = 3'd1,
    REG_STRIKE        = 3'd2,
    REG_ACTIVE_ASSETS = 3'd3,
    REG_WEIGHT_FIRST  = 3'd4,
    REG_WEIGHT_SECOND = 3'd5,
    REG_WEIGHT_THIRD  = 3'd6,
    REG_WEIGHT_FOURTH = 3'd7
  } cfg_index_e;

  typedef logic [NumAssets-1:0][PriceW-1:0]  prices_t;
  typedef logic [NumAssets-1:0][WeightW-1:0] weights_t;

  // configuration as the datapath sees it
  typedef struct packed {
    payoff_kind_e       kind;
    logic               call_not_put;
    logic signed [31:0] strike;
    logic               use_third;
    logic               use_fourth;
    weights_t           weights;
  } cfg_t;

endpackage

// ===== hdl/multi_asset_option_payoff_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_asset_option_payoff_top
// Option payoff for one vector of four asset prices per transaction.
// ----------------------------------------------------------------------------
// The block takes a price vector on every cycle that start is high (busy
// stays low) and returns its payoff at the end of the pipeline, with done_o
// high for a single cycle; results keep the order of the transactions and the
// receiver must take each one as it appears. The four pipeline stages are the
// price-by-weight multipliers, the pair sums, the operand select and the
// strike subtract with clamping. Write configuration only while no
// transaction is in flight.
module multi_asset_option_payoff_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [maop_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [maop_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   price_first_i,
  input  logic [31:0]                   price_second_i,
  input  logic [31:0]                   price_third_i,
  input  logic [31:0]                   price_fourth_i,
  output logic                          done_o,
  output logic [31:0]                   payoff_value_o,
  output logic                          saturated_o
);
  import maop_pkg::*;

  cfg_t    cfg;
  prices_t prices;
  logic    accept;

  // the pipeline never stalls, so a transaction is always taken
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign prices = {price_fourth_i, price_third_i, price_second_i, price_first_i};

  maop_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  maop_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (accept),
    .prices_i    (prices),
    .out_valid_o (done_o),
    .payoff_o    (payoff_value_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== hdl/maop_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maop_cfg
// Configuration registers; decodes the active asset count into lane enables.
// ----------------------------------------------------------------------------
module maop_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [maop_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [maop_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output maop_pkg::cfg_t                     cfg_o
);
  import maop_pkg::*;

  logic [2:0]         kind_q;
  logic               cnp_q;
  logic [31:0]        strike_q;
  logic [2:0]         active_q;
  weights_t           weights_q;
  cfg_index_e         idx;

  assign idx = cfg_index_e'(cfg_idx_i);

  // write one register per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_BASKET;
      cnp_q     <= 1'b1;
      strike_q  <= '0;
      active_q  <= 3'd4;
      weights_q <= {NumAssets{WeightW'(16384)}};
    end else if (cfg_we_i) begin
      unique case (idx)
        REG_PAYOFF_KIND:   kind_q       <= cfg_wdata_i[2:0];
        REG_CALL_NOT_PUT:  cnp_q        <= cfg_wdata_i[0];
        REG_STRIKE:        strike_q     <= cfg_wdata_i[31:0];
        REG_ACTIVE_ASSETS: active_q     <= cfg_wdata_i[2:0];
        REG_WEIGHT_FIRST:  weights_q[0] <= cfg_wdata_i[WeightW-1:0];
        REG_WEIGHT_SECOND: weights_q[1] <= cfg_wdata_i[WeightW-1:0];
        REG_WEIGHT_THIRD:  weights_q[2] <= cfg_wdata_i[WeightW-1:0];
        REG_WEIGHT_FOURTH: weights_q[3] <= cfg_wdata_i[WeightW-1:0];
        default:           kind_q       <= kind_q;
      endcase
    end
  end

  // clamp the active count: below three uses two assets, above four uses four
  always_comb begin
    cfg_o.kind         = payoff_kind_e'(kind_q);
    cfg_o.call_not_put = cnp_q;
    cfg_o.strike       = $signed(strike_q);
    cfg_o.use_third    = (active_q >= 3'd3);
    cfg_o.use_fourth   = (active_q >= 3'd4);
    cfg_o.weights      = weights_q;
  end

endmodule

// ===== hdl/maop_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maop_pipe
// Four-stage payoff datapath: products and pairwise extremes, partial sums,
// operand select, strike and clamp.
// ----------------------------------------------------------------------------
module maop_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  maop_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  input  maop_pkg::prices_t     prices_i,
  output logic                  out_valid_o,
  output logic [31:0]           payoff_o,
  output logic                  saturated_o
);
  import maop_pkg::*;

  logic best;
  assign best = (cfg_i.kind == KIND_BEST_OF);

  function automatic logic [PriceW-1:0] pick(input logic is_best,
                                             input logic [PriceW-1:0] a,
                                             input logic [PriceW-1:0] b);
    logic [PriceW-1:0] r;
    if (is_best) r = (b > a) ? b : a;
    else         r = (b < a) ? b : a;
    return r;
  endfunction

  // ---------------- stage 1: weighted terms, pairwise extremes, difference
  logic                          v1_q;
  logic [NumAssets-1:0][TermW-1:0] term_d, term_q;
  logic [PriceW-1:0]             m01_q, m23_q;
  logic signed [PriceW:0]        diff1_q;
  logic [ProdW-1:0]              prod [NumAssets];

  always_comb begin
    for (int i = 0; i < NumAssets; i++) begin
      prod[i]   = ProdW'(prices_i[i]) * ProdW'(cfg_i.weights[i]);
      term_d[i] = prod[i][ProdW-1:WeightFrac];
    end
    if (!cfg_i.use_third)  term_d[2] = '0;
    if (!cfg_i.use_fourth) term_d[3] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    m01_q   <= pick(best, prices_i[0], prices_i[1]);
    m23_q   <= cfg_i.use_fourth ? pick(best, prices_i[2], prices_i[3]) : prices_i[2];
    diff1_q <= $signed({1'b0, prices_i[0]}) - $signed({1'b0, prices_i[1]});
  end

  // ---------------- stage 2: pair sums, final extreme
  logic                   v2_q;
  logic [PairW-1:0]       s01_q, s23_q;
  logic [PriceW-1:0]      ext_q;
  logic signed [PriceW:0] diff2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    s01_q   <= PairW'(term_q[0]) + PairW'(term_q[1]);
    s23_q   <= PairW'(term_q[2]) + PairW'(term_q[3]);
    ext_q   <= cfg_i.use_third ? pick(best, m01_q, m23_q) : m01_q;
    diff2_q <= diff1_q;
  end

  // ---------------- stage 3: select the operand for the kind
  logic                 v3_q;
  logic signed [XW-1:0] x_d, x_q;
  logic                 use_k_d, use_k_q;
  logic                 zero_d, zero_q;
  logic [SumW-1:0]      basket;

  assign basket = SumW'(s01_q) + SumW'(s23_q);

  always_comb begin
    x_d     = '0;
    use_k_d = 1'b0;
    zero_d  = 1'b0;
    unique case (cfg_i.kind)
      KIND_BASKET: begin
        x_d     = $signed({1'b0, basket});
        use_k_d = 1'b1;
      end
      KIND_BEST_OF, KIND_WORST_OF: begin
        x_d     = $signed({{(XW-PriceW){1'b0}}, ext_q});
        use_k_d = 1'b1;
      end
      KIND_EXCHANGE: begin
        x_d     = XW'(diff2_q);
      end
      KIND_SPREAD: begin
        x_d     = XW'(diff2_q);
        use_k_d = 1'b1;
      end
      default: begin
        zero_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    use_k_q <= use_k_d;
    zero_q  <= zero_d;
  end

  // ---------------- stage 4: apply strike, floor at zero, saturate
  logic signed [VW-1:0] xv, kv, v;
  logic [31:0]          pay_d;
  logic                 sat_d;
  logic                 v4_q;
  logic [31:0]          pay_q;
  logic                 sat_q;

  always_comb begin
    xv = VW'(x_q);
    kv = VW'($signed(cfg_i.strike));
    if (!use_k_q)                v = xv;
    else if (cfg_i.call_not_put) v = xv - kv;
    else                         v = kv - xv;
    pay_d = '0;
    sat_d = 1'b0;
    if (zero_q || v[VW-1]) begin
      pay_d = '0;
    end else if (v[VW-2:32] != '0) begin
      pay_d = '1;
      sat_d = 1'b1;
    end else begin
      pay_d = v[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    sat_q <= sat_d;
  end

  assign out_valid_o = v4_q;
  assign payoff_o    = pay_q;
  assign saturated_o = sat_q;

endmodule

// ===== verif/tb_multi_asset_option_payoff_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_asset_option_payoff_top
// Self-checking bench for the multi-asset option payoff block.
// ----------------------------------------------------------------------------
// A queue of pending entries (price vectors, register writes, drains and
// sender idle rates) is filled up front and fed to the block by a clocked
// driver. Each accepted price vector is priced by a local payoff model that
// keeps its own copy of the registers, and the expected payoff is queued. A
// clocked monitor compares every strobed result with the oldest expected
// payoff. Registers change only once all expected payoffs have arrived.
module tb_multi_asset_option_payoff_top;

  import maop_pkg::*;

  localparam logic [31:0] PriceMax     = 32'hFFFF_FFFF;
  localparam logic [31:0] PriceOne     = 32'h0001_0000;
  localparam logic [31:0] StrikeMin    = 32'h8000_0000;
  localparam logic [31:0] StrikeMax    = 32'h7FFF_FFFF;
  localparam logic [16:0] WeightMax    = 17'h1_FFFF;
  localparam logic [16:0] WeightQuart  = 17'h0_4000;
  localparam logic [16:0] WeightUnity  = 17'h1_0000;
  localparam logic [2:0]  KindUndefLo  = 3'd5;
  localparam logic [2:0]  KindUndefHi  = 3'd7;
  localparam longint      PayoffMax    = 64'h0000_0000_FFFF_FFFF;
  localparam int          MaxPrinted   = 50;

  typedef enum logic [1:0] {
    ENT_PRICES,
    ENT_WRITE,
    ENT_DRAIN,
    ENT_RATE
  } entry_op_e;

  typedef struct {
    entry_op_e   op;
    cfg_index_e  idx;
    logic [31:0] data;
    prices_t     prices;
  } stim_entry_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } payoff_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_idx     = '0;
  logic [31:0] cfg_wdata   = '0;
  logic        start       = 1'b0;
  logic        busy;
  logic [31:0] price_first  = '0;
  logic [31:0] price_second = '0;
  logic [31:0] price_third  = '0;
  logic [31:0] price_fourth = '0;
  logic        done;
  logic [31:0] payoff_value;
  logic        saturated;

  // register copy of the payoff model, at reset values
  logic [2:0]  kind_q   = KIND_BASKET;
  logic        call_q   = 1'b1;
  logic [31:0] strike_q = '0;
  logic [2:0]  active_q = 3'd4;
  weights_t    weight_q = {4{WeightQuart}};

  stim_entry_t stim_q[$];
  payoff_t     payoff_due[$];
  int          gap_pct = 0;
  int          acc_cnt = 0;
  int          rx_cnt  = 0;
  int          err_cnt = 0;

  multi_asset_option_payoff_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .price_first_i  (price_first),
    .price_second_i (price_second),
    .price_third_i  (price_third),
    .price_fourth_i (price_fourth),
    .done_o         (done),
    .payoff_value_o (payoff_value),
    .saturated_o    (saturated)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Payoff model
  // ------------

  function automatic void apply_write(input cfg_index_e idx, input logic [31:0] d);
    case (idx)
      REG_PAYOFF_KIND:   kind_q      = d[2:0];
      REG_CALL_NOT_PUT:  call_q      = d[0];
      REG_STRIKE:        strike_q    = d;
      REG_ACTIVE_ASSETS: active_q    = d[2:0];
      REG_WEIGHT_FIRST:  weight_q[0] = d[16:0];
      REG_WEIGHT_SECOND: weight_q[1] = d[16:0];
      REG_WEIGHT_THIRD:  weight_q[2] = d[16:0];
      REG_WEIGHT_FOURTH: weight_q[3] = d[16:0];
      default: ;
    endcase
  endfunction

  function automatic longint against_strike(input longint x);
    longint k;
    k = longint'($signed(strike_q));
    return call_q ? (x - k) : (k - x);
  endfunction

  function automatic payoff_t option_payoff(input prices_t px);
    longint          v;
    longint          p0;
    longint          p1;
    longint unsigned basket;
    logic [31:0]     ext;
    int              n;
    payoff_t         r;
    // clamp the asset count to the fields present
    n = int'(active_q);
    if (n < 2) n = 2;
    if (n > 4) n = 4;
    p0 = longint'(px[0]);
    p1 = longint'(px[1]);
    v  = 0;
    case (kind_q)
      KIND_BASKET: begin
        basket = 0;
        for (int i = 0; i < n; i++) begin
          basket += (64'(px[i]) * 64'(weight_q[i])) >> WeightFrac;
        end
        v = against_strike(longint'(basket));
      end
      KIND_BEST_OF, KIND_WORST_OF: begin
        ext = px[0];
        for (int i = 1; i < n; i++) begin
          if (kind_q == KIND_BEST_OF ? (px[i] > ext) : (px[i] < ext)) ext = px[i];
        end
        v = against_strike(longint'({32'd0, ext}));
      end
      KIND_EXCHANGE: v = p0 - p1;
      KIND_SPREAD:   v = against_strike(p0 - p1);
      default:       v = 0;
    endcase
    // floor at zero, saturate above the output range
    if (v < 0) v = 0;
    if (v > PayoffMax) begin
      r.value = PriceMax;
      r.sat   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Driver
  // ------

  always @(posedge clk_i) begin
    stim_entry_t head;
    logic        offer;
    logic        we_next;
    if (!rst_ni) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      offer   = 1'b0;
      we_next = 1'b0;
      // retire the transaction taken at this edge
      if (start && !busy) begin
        payoff_due.push_back(option_payoff({price_fourth, price_third,
                                            price_second, price_first}));
        acc_cnt++;
      end
      if (start && busy) begin
        // hold the offered transaction until it is taken
        offer = 1'b1;
      end else if (stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.op)
          ENT_PRICES: begin
            if ($urandom_range(0, 99) >= gap_pct) begin
              price_first  <= head.prices[0];
              price_second <= head.prices[1];
              price_third  <= head.prices[2];
              price_fourth <= head.prices[3];
              offer = 1'b1;
              stim_q.delete(0);
            end
          end
          ENT_WRITE: begin
            if (rx_cnt >= acc_cnt) begin
              we_next = 1'b1;
              cfg_idx   <= head.idx;
              cfg_wdata <= head.data;
              apply_write(head.idx, head.data);
              stim_q.delete(0);
            end
          end
          ENT_DRAIN: begin
            if (rx_cnt >= acc_cnt) stim_q.delete(0);
          end
          default: begin
            gap_pct = head.data;
            stim_q.delete(0);
          end
        endcase
      end
      start  <= offer;
      cfg_we <= we_next;
    end
  end

  // Monitor
  // -------

  always @(posedge clk_i) begin
    payoff_t want;
    if (rst_ni && done) begin
      rx_cnt <= rx_cnt + 1;
      if (payoff_due.size() == 0) begin
        report_mismatch("payoff with no transaction waiting", payoff_value, '0);
      end else begin
        want = payoff_due.pop_front();
        if (payoff_value !== want.value) begin
          report_mismatch("payoff_value", payoff_value, want.value);
        end
        if (saturated !== want.sat) begin
          report_mismatch("saturated", {31'd0, saturated}, {31'd0, want.sat});
        end
      end
    end
  end

  // Stimulus builders
  // -----------------

  task automatic push_prices(input logic [31:0] p0, input logic [31:0] p1,
                             input logic [31:0] p2, input logic [31:0] p3);
    stim_entry_t e;
    e.op     = ENT_PRICES;
    e.idx    = REG_PAYOFF_KIND;
    e.data   = '0;
    e.prices = {p3, p2, p1, p0};
    stim_q.push_back(e);
  endtask

  task automatic push_write(input cfg_index_e idx, input logic [31:0] value);
    stim_entry_t e;
    int          w;
    logic [31:0] mask;
    case (idx)
      REG_PAYOFF_KIND, REG_ACTIVE_ASSETS: w = 3;
      REG_CALL_NOT_PUT:                   w = 1;
      REG_STRIKE:                         w = 32;
      default:                            w = WeightW;
    endcase
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 1);
    e.op     = ENT_WRITE;
    e.idx    = idx;
    e.data   = value & mask;
    e.prices = '0;
    // now and then set junk above the register width
    if ($urandom_range(0, 3) == 0) e.data |= $urandom & ~mask;
    stim_q.push_back(e);
  endtask

  task automatic push_marker(input entry_op_e op, input int value);
    stim_entry_t e;
    e.op     = op;
    e.idx    = REG_PAYOFF_KIND;
    e.data   = value;
    e.prices = '0;
    stim_q.push_back(e);
  endtask

  function automatic logic [31:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PriceMax;
      2:       return $urandom_range(0, 32'h0010_0000);
      3:       return PriceMax - $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WeightMax;
      2:       return WeightQuart;
      3:       return WeightUnity;
      default: return $urandom_range(0, WeightMax);
    endcase
  endfunction

  task automatic add_random_config();
    logic [31:0] s;
    if ($urandom_range(0, 9) == 0) begin
      push_write(REG_PAYOFF_KIND, $urandom_range(KindUndefLo, KindUndefHi));
    end else begin
      push_write(REG_PAYOFF_KIND, $urandom_range(KIND_BASKET, KIND_SPREAD));
    end
    push_write(REG_CALL_NOT_PUT, $urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: s = '0;
      1: s = StrikeMin;
      2: s = StrikeMax;
      3, 4: begin
        s = $urandom_range(0, 32'h03FF_FFFF);
        if ($urandom_range(0, 1)) s = -s;
      end
      default: s = $urandom;
    endcase
    push_write(REG_STRIKE, s);
    if ($urandom_range(0, 9) < 7) begin
      push_write(REG_ACTIVE_ASSETS, $urandom_range(2, 4));
    end else begin
      push_write(REG_ACTIVE_ASSETS, $urandom_range(0, 7));
    end
    push_write(REG_WEIGHT_FIRST,  rand_weight());
    push_write(REG_WEIGHT_SECOND, rand_weight());
    push_write(REG_WEIGHT_THIRD,  rand_weight());
    push_write(REG_WEIGHT_FOURTH, rand_weight());
  endtask

  task automatic push_random_vector();
    logic [31:0] px [4];
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0:       px[i] = rand_price();
        1:       px[i] = base + $urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF;
        2:       px[i] = $urandom_range(0, 32'h00FF_FFFF);
        default: px[i] = $urandom;
      endcase
    end
    push_prices(px[0], px[1], px[2], px[3]);
  endtask

  // one idle regime: short phases, each under a fresh register setting
  task automatic add_regime(input int gap, input int items);
    int left;
    int len;
    push_marker(ENT_RATE, gap);
    left = items;
    while (left > 0) begin
      len = $urandom_range(20, 100);
      if (len > left) len = left;
      add_random_config();
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 49) == 0) push_marker(ENT_DRAIN, 0);
        push_random_vector();
      end
      left -= len;
    end
  endtask

  // Directed part, random regimes, then the end of the run
  // ------------------------------------------------------

  initial begin
    push_marker(ENT_RATE, 28);
    // reset setting: call basket of four at a quarter each, zero strike
    push_prices('0, '0, '0, '0);
    push_prices(PriceMax, PriceMax, PriceMax, PriceMax);
    push_prices(PriceOne, 2 * PriceOne, 3 * PriceOne, 4 * PriceOne);
    // full weights push the basket beyond the output range
    push_write(REG_WEIGHT_FIRST,  WeightMax);
    push_write(REG_WEIGHT_SECOND, WeightMax);
    push_write(REG_WEIGHT_THIRD,  WeightMax);
    push_write(REG_WEIGHT_FOURTH, WeightMax);
    push_prices(PriceMax, PriceMax, PriceMax, PriceMax);
    push_prices(PriceMax, '0, '0, '0);
    // most negative strike: put floors at zero, call lifts by the strike
    push_write(REG_CALL_NOT_PUT, 1'b0);
    push_write(REG_STRIKE, StrikeMin);
    push_prices('0, '0, '0, '0);
    push_write(REG_CALL_NOT_PUT, 1'b1);
    push_prices('0, '0, '0, '0);
    // best-of put on two assets against the largest strike
    push_write(REG_PAYOFF_KIND, KIND_BEST_OF);
    push_write(REG_CALL_NOT_PUT, 1'b0);
    push_write(REG_STRIKE, StrikeMax);
    push_write(REG_ACTIVE_ASSETS, 3'd2);
    push_prices(PriceOne, 2 * PriceOne, PriceMax, PriceMax);
    push_prices(PriceMax, '0, '0, '0);
    // payoff of exactly the top value is not saturated
    push_write(REG_CALL_NOT_PUT, 1'b1);
    push_write(REG_STRIKE, '0);
    push_write(REG_ACTIVE_ASSETS, 3'd3);
    push_prices('0, PriceMax, '0, PriceMax);
    // worst-of with asset counts below and above the valid range
    push_write(REG_PAYOFF_KIND, KIND_WORST_OF);
    push_write(REG_ACTIVE_ASSETS, 3'd0);
    push_prices(3 * PriceOne, 5 * PriceOne, '0, '0);
    push_write(REG_ACTIVE_ASSETS, 3'd7);
    push_prices(3 * PriceOne, 5 * PriceOne, 2 * PriceOne, PriceOne);
    // exchange ignores the strike and the call or put sense
    push_write(REG_PAYOFF_KIND, KIND_EXCHANGE);
    push_write(REG_CALL_NOT_PUT, 1'b0);
    push_write(REG_STRIKE, StrikeMax);
    push_prices(5 * PriceOne, 3 * PriceOne, '0, '0);
    push_prices(3 * PriceOne, 5 * PriceOne, '0, '0);
    push_prices(PriceMax, '0, PriceMax, PriceMax);
    // spread call and put at the strike extremes
    push_write(REG_PAYOFF_KIND, KIND_SPREAD);
    push_write(REG_CALL_NOT_PUT, 1'b1);
    push_write(REG_STRIKE, StrikeMin);
    push_prices(PriceMax, '0, '0, '0);
    push_prices(PriceOne, PriceOne, '0, '0);
    push_write(REG_CALL_NOT_PUT, 1'b0);
    push_write(REG_STRIKE, StrikeMax);
    push_prices('0, PriceMax, '0, '0);
    push_prices(PriceMax, '0, '0, '0);
    // undefined kinds give a zero payoff
    push_write(REG_PAYOFF_KIND, KindUndefLo);
    push_prices(PriceMax, '0, PriceMax, PriceMax);
    push_write(REG_PAYOFF_KIND, KindUndefHi);
    push_prices(PriceMax, PriceMax, PriceMax, PriceMax);

    add_regime(28, 600);
    add_regime(62, 600);
    add_regime(0, 600);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to run dry and every payoff to come back
    while (stim_q.size() != 0 || start || rx_cnt < acc_cnt) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (payoff_due.size() != 0) begin
      report_mismatch("payoffs never returned", '0, payoff_due.size());
    end
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
